// ===== rtl/core/kdsl_pkg.sv =====
// shared types and constants for the six-key debouncer with short and long press events
// no dependencies; used by kdsl_cell and key_debounce_short_long_press
package kdsl_pkg;

    localparam int NUM_KEYS = 6;
    localparam int CNT_W    = 8;
    localparam int TICK_W   = 32;
    localparam int LPT_W    = 16;
    localparam int CODE_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] CNT_MAX       = 8'hFF;
    localparam logic [CNT_W-1:0] DEBOUNCE_RST  = 8'd2;
    localparam logic [LPT_W-1:0] LONG_TICK_RST = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;

    // event codes
    localparam logic [CODE_W-1:0] EV_NONE        = 3'd0;
    localparam logic [CODE_W-1:0] EV_RIGHT_SHORT = 3'd1;
    localparam logic [CODE_W-1:0] EV_RIGHT_LONG  = 3'd2;
    localparam logic [CODE_W-1:0] EV_LEFT_LONG   = 3'd3;
    localparam logic [CODE_W-1:0] EV_UP          = 3'd4;
    localparam logic [CODE_W-1:0] EV_DOWN        = 3'd5;
    localparam logic [CODE_W-1:0] EV_LEFT        = 3'd6;
    localparam logic [CODE_W-1:0] EV_RIGHT_ALT   = 3'd7;

    localparam logic [CODE_W-1:0] SHORT_CODE [NUM_KEYS] =
        '{EV_RIGHT_SHORT, EV_NONE, EV_UP, EV_DOWN, EV_LEFT, EV_RIGHT_ALT};
    localparam logic [CODE_W-1:0] LONG_CODE [NUM_KEYS] =
        '{EV_RIGHT_LONG, EV_LEFT_LONG, EV_NONE, EV_NONE, EV_NONE, EV_NONE};

    typedef struct packed {
        logic [CNT_W-1:0] debounce_count;
        logic [LPT_W-1:0] long_press_ticks;
    } cfg_t;

    // scan item walking down the row of key cells
    typedef struct packed {
        logic [NUM_KEYS-1:0] key_levels;
        logic [TICK_W-1:0]   now_tick;
        logic                done;
        logic [CODE_W-1:0]   event_code;
    } tok_t;

endpackage

// ===== rtl/core/key_debounce_short_long_press.sv =====
// top level of the six-key debouncer: scan input, event output, config port
// depends on kdsl_pkg and kdsl_cell
//
// usage:
//   s_* takes one scan item (six active-low key levels, 32-bit wrapping tick);
//   m_* gives exactly one event code per scan. cfg_we/cfg_index/cfg_data write
//   debounce_count (index 0) and long_press_ticks (index 1); other indexes
//   are ignored. write only while no scan is in flight.
// timing:
//   the scan item walks a row of six key cells, one key per cycle, in key
//   order, unless the last cell holds on a full output; the first key that
//   reports ends processing and later cells pass the item through untouched.
//   the event is loaded into the output register as the item leaves the last
//   cell. s_tready is low from the accept until the event is loaded, so a new
//   scan is taken only once the last one's event is in the output register.
// stall:
//   a finished event waits in the output register while the next scan is
//   taken; if it is still waiting when the next event reaches the last cell,
//   that cell and its item hold until m_tready frees the register.
// reset: key state clears, debounce_count is 2, long_press_ticks 1000
module key_debounce_short_long_press
    import kdsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // key_levels[5:0], now_tick[37:6], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // event_code[2:0], zero pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              busy_reg;
    logic              out_vld_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [NUM_KEYS-1:0] tok_vld_reg;
    tok_t              tok_reg [NUM_KEYS];
    tok_t              cell_out [NUM_KEYS];
    logic              s_accept;
    logic              out_free;
    logic              out_load;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign out_load = tok_vld_reg[NUM_KEYS-1] && out_free;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(8-CODE_W){1'b0}}, out_code_reg};

    genvar k;
    generate
        for (k = 0; k < NUM_KEYS; k++)
        begin : g_cell
            kdsl_cell #(
                .KEY_IDX (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cfg     (cfg_reg),
                .tok_vld (tok_vld_reg[k]),
                .tok_in  (tok_reg[k]),
                .en      ((k == NUM_KEYS-1) ? out_free : 1'b1),
                .tok_out (cell_out[k])
            );
        end
    endgenerate

    // item payload moves one cell per cycle, but the last cell holds while the output is full
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            tok_reg[0].key_levels <= s_tdata[5:0];
            tok_reg[0].now_tick   <= s_tdata[37:6];
            tok_reg[0].done       <= 1'b0;
            tok_reg[0].event_code <= EV_NONE;
        end
        for (int i = 1; i < NUM_KEYS - 1; i++)
        begin
            tok_reg[i] <= cell_out[i-1];
        end
        // last cell keeps its item while the output is full
        if (tok_vld_reg[NUM_KEYS-2])
        begin
            tok_reg[NUM_KEYS-1] <= cell_out[NUM_KEYS-2];
        end
        if (out_load)
        begin
            out_code_reg <= cell_out[NUM_KEYS-1].event_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_count   <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= LONG_TICK_RST;
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            tok_vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEBOUNCE_COUNT)
                begin
                    cfg_reg.debounce_count <= cfg_data[CNT_W-1:0];
                end
                else if (cfg_index == REG_LONG_PRESS_TICKS)
                begin
                    cfg_reg.long_press_ticks <= cfg_data[LPT_W-1:0];
                end
            end

            tok_vld_reg[0] <= s_accept;
            for (int i = 1; i < NUM_KEYS - 1; i++)
            begin
                tok_vld_reg[i] <= tok_vld_reg[i-1];
            end
            tok_vld_reg[NUM_KEYS-1] <= tok_vld_reg[NUM_KEYS-2]
                                      || (tok_vld_reg[NUM_KEYS-1] && !out_free);

            if (s_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/kdsl_cell.sv =====
// one key cell: debounce state, press stamp and long flag of a single key
// depends on kdsl_pkg; instantiated once per key by key_debounce_short_long_press
module kdsl_cell
    import kdsl_pkg::*;
#(
    parameter int KEY_IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic tok_vld,
    input  tok_t tok_in,
    input  logic en,
    output tok_t tok_out
);

    logic              last_raw_reg, last_raw_next;
    logic              stable_reg, stable_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;
    logic              long_done_reg, long_done_next;
    logic [TICK_W-1:0] stamp_reg, stamp_next;

    always_comb
    begin
        logic              pressed;
        logic              change;
        logic              commit;
        logic [TICK_W-1:0] elapsed;

        pressed = ~tok_in.key_levels[KEY_IDX];
        commit  = tok_vld && en && !tok_in.done;
        tok_out = tok_in;

        last_raw_next  = pressed;
        stable_next    = stable_reg;
        long_done_next = long_done_reg;
        stamp_next     = stamp_reg;

        if (pressed == last_raw_reg)
        begin
            run_cnt_next = (run_cnt_reg == CNT_MAX) ? run_cnt_reg : run_cnt_reg + 1'b1;
        end
        else
        begin
            run_cnt_next = '0;
        end

        change = (run_cnt_next >= cfg.debounce_count) && (pressed != stable_reg);
        if (change)
        begin
            stable_next = pressed;
            if (pressed)
            begin
                stamp_next     = tok_in.now_tick;
                long_done_next = 1'b0;
            end
        end

        elapsed = tok_in.now_tick - stamp_next;

        if (!tok_in.done)
        begin
            if (change && !pressed && !long_done_reg)
            begin
                // short event on release
                tok_out.done       = 1'b1;
                tok_out.event_code = SHORT_CODE[KEY_IDX];
            end
            else if (stable_next && !long_done_next
                     && elapsed >= {{(TICK_W-LPT_W){1'b0}}, cfg.long_press_ticks})
            begin
                long_done_next     = 1'b1;
                tok_out.done       = 1'b1;
                tok_out.event_code = LONG_CODE[KEY_IDX];
            end
        end

        if (!commit)
        begin
            last_raw_next  = last_raw_reg;
            stable_next    = stable_reg;
            run_cnt_next   = run_cnt_reg;
            long_done_next = long_done_reg;
            stamp_next     = stamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg  <= 1'b0;
            stable_reg    <= 1'b0;
            run_cnt_reg   <= '0;
            long_done_reg <= 1'b0;
            stamp_reg     <= '0;
        end
        else
        begin
            last_raw_reg  <= last_raw_next;
            stable_reg    <= stable_next;
            run_cnt_reg   <= run_cnt_next;
            long_done_reg <= long_done_next;
            stamp_reg     <= stamp_next;
        end
    end

endmodule

// ===== rtl/core/kdsl_checker.sv =====
// port-level checks for key_debounce_short_long_press, attached by bind
// no package dependency; watches the handshake ports of the top level
module kdsl_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [7:0]            m_tdata
);

    // one scan at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("scan taken while another is in flight");

    // an item accepted with an empty output shows its event once it leaves the cell row
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !m_tvalid) |-> ##7 m_tvalid)
        else $error("event missing seven cycles after scan");

    // no event appears without a scan in flight or one just finished
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_tvalid)) |-> !$past(s_tready))
        else $error("event produced with no scan in flight");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:3] == 5'd0))
        else $error("output pad bits not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled event changed");

endmodule

bind key_debounce_short_long_press kdsl_checker u_kdsl_checker (.*);

// ===== sim/tb_key_debounce_short_long_press.sv =====
// self-checking testbench for key_debounce_short_long_press: scan items in, event items out
// depends on kdsl_pkg and the top-level RTL; carries its own debounce predictor
module tb_key_debounce_short_long_press;
    import kdsl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [NUM_KEYS-1:0] levels;
        logic [TICK_W-1:0]   tick;
    } scan_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    key_debounce_short_long_press dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor copy of the key state and registers
    logic [CNT_W-1:0]    deb_cfg = DEBOUNCE_RST;
    logic [LPT_W-1:0]    lpt_cfg = LONG_TICK_RST;
    logic [NUM_KEYS-1:0] raw_q = '0;
    logic [NUM_KEYS-1:0] stable_q = '0;
    logic [NUM_KEYS-1:0] long_sent_q = '0;
    logic [CNT_W-1:0]    run_q [NUM_KEYS] = '{default: '0};
    logic [TICK_W-1:0]   stamp_q [NUM_KEYS] = '{default: '0};

    scan_t             scan_q [$];
    logic [CODE_W-1:0] event_q [$];

    int          n_issued = 0;
    int          n_accepted = 0;
    int          n_events = 0;
    int          n_results = 0;
    int          err_count = 0;
    int          pushed = 0;
    int          settings_used = 1;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_cnt = 0;
    int          quiet = 0;
    bit          calm = 1'b0;
    logic [31:0] cur_tick = '0;

    function automatic logic [CODE_W-1:0] scan_event(input logic [NUM_KEYS-1:0] levels,
                                                      input logic [TICK_W-1:0] now);
        logic              pressed;
        logic [TICK_W-1:0] held;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            pressed = ~levels[k];
            if (pressed == raw_q[k])
            begin
                if (run_q[k] != CNT_MAX)
                    run_q[k] = run_q[k] + 1'b1;
            end
            else
            begin
                raw_q[k] = pressed;
                run_q[k] = '0;
            end
            if (run_q[k] >= deb_cfg && pressed != stable_q[k])
            begin
                stable_q[k] = pressed;
                if (pressed)
                begin
                    stamp_q[k] = now;
                    long_sent_q[k] = 1'b0;
                end
                else if (!long_sent_q[k])
                    return SHORT_CODE[k];
            end
            held = now - stamp_q[k];
            if (stable_q[k] && !long_sent_q[k] && held >= {16'b0, lpt_cfg})
            begin
                long_sent_q[k] = 1'b1;
                return LONG_CODE[k];
            end
        end
        return EV_NONE;
    endfunction

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // sender: holds an item until taken, random gaps between items unless calm
    always @(negedge clk)
    begin : drive_blk
        scan_t nxt;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || n_accepted == n_issued)
        begin
            if (!calm && gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (scan_q.size() > 0)
            begin
                nxt = scan_q.pop_front();
                s_tdata  <= {2'b00, nxt.tick, nxt.levels};
                s_tvalid <= 1'b1;
                n_issued++;
                if (!calm && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stall bursts unless calm, plus one long hold on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (!calm && stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 9);
            end
        end
    end

    // monitor: predict on input accept, compare on output accept
    always @(posedge clk)
    begin : check_blk
        logic [CODE_W-1:0] want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                event_q.push_back(scan_event(s_tdata[5:0], s_tdata[37:6]));
                n_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (event_q.size() == 0)
                    report($sformatf("event item 0x%02h with nothing expected", m_tdata));
                else
                begin
                    want = event_q.pop_front();
                    if (want != EV_NONE)
                        n_events++;
                    if (m_tdata[2:0] != want)
                        report($sformatf("event_code %0d, expected %0d", m_tdata[2:0], want));
                    if (m_tdata[7:3] != '0)
                        report($sformatf("pad bits of event item not zero: 0x%02h", m_tdata));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb_key_debounce_short_long_press failed");
                $finish;
            end
        end
    end

    task automatic push_scan(input logic [NUM_KEYS-1:0] lv, input int unsigned step);
        scan_t s;
        s.levels = lv;
        s.tick   = cur_tick;
        scan_q.push_back(s);
        pushed++;
        cur_tick = cur_tick + step;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (scan_q.size() != 0 || n_issued != n_accepted || event_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DEBOUNCE_COUNT)
            deb_cfg = val[CNT_W-1:0];
        else if (idx == REG_LONG_PRESS_TICKS)
            lpt_cfg = val;
    endtask

    task automatic set_phase(input logic [CNT_W-1:0] deb, input logic [LPT_W-1:0] lpt);
        wait_drained();
        repeat (12) @(negedge clk);
        // upper bits of the debounce write must be dropped
        write_cfg(REG_DEBOUNCE_COUNT, {8'($urandom), deb});
        write_cfg(REG_SPARE_A, 16'($urandom));
        write_cfg(REG_LONG_PRESS_TICKS, lpt);
        write_cfg(REG_SPARE_B, 16'($urandom));
        settings_used++;
    endtask

    // bounce, press, bounce, release on one key with random tick steps
    task automatic key_gesture(input int key, input int hold);
        logic [NUM_KEYS-1:0] others;
        logic [NUM_KEYS-1:0] lv;
        int unsigned         step_max;
        others = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'h3F;
        if (hold == 0)
            hold = $urandom_range(1, int'(deb_cfg) + 6);
        step_max = (int'(lpt_cfg) * 2) / hold + 1;
        repeat ($urandom_range(0, 2))
        begin
            lv = others;
            lv[key] = 1'($urandom);
            push_scan(lv, $urandom_range(0, step_max));
        end
        repeat (hold)
        begin
            lv = others;
            lv[key] = 1'b0;
            push_scan(lv, $urandom_range(0, step_max));
        end
        repeat ($urandom_range(0, 2))
        begin
            lv = others;
            lv[key] = 1'($urandom);
            push_scan(lv, $urandom_range(0, step_max));
        end
        repeat (int'(deb_cfg) + 1 + $urandom_range(0, 2))
            push_scan(6'h3F, $urandom_range(0, step_max));
    endtask

    task automatic noise(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 7) == 0)
                cur_tick = $urandom;
            push_scan(6'($urandom), $urandom_range(0, 500));
        end
    endtask

    task automatic random_fill(input int n);
        int target;
        target = pushed + n;
        while (pushed < target)
        begin
            if ($urandom_range(0, 9) < 8)
                key_gesture($urandom_range(0, NUM_KEYS - 1), 0);
            else
                noise($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: debounce 2, long press 1000
        cur_tick = 32'd0;
        repeat (3) push_scan(6'h3F, 1);
        cur_tick = 32'd10;
        repeat (3) push_scan(6'h00, 1);
        // every key long in turn, one per scan, keys without a long code give none
        cur_tick = 32'd1012;
        repeat (6) push_scan(6'h00, 0);
        push_scan(6'h00, 1);
        // release after long events reports nothing
        cur_tick = 32'd2000;
        repeat (3) push_scan(6'h3F, 1);
        // two keys released together: the second waits for the next scan
        repeat (3) push_scan(6'h33, 1);
        repeat (5) push_scan(6'h3F, 1);
        // long press across the tick wrap
        cur_tick = 32'hFFFF_FF00;
        repeat (3) push_scan(6'h3E, 0);
        cur_tick = 32'h0000_02F0;
        push_scan(6'h3E, 1);
        repeat (3) push_scan(6'h3F, 1);
        // short press of key 1, which has no short code, together with key 5
        repeat (3) push_scan(6'h1D, 1);
        repeat (5) push_scan(6'h3F, 1);

        // zero debounce and zero long-press time
        cur_tick = $urandom;
        set_phase(8'd0, 16'd0);
        random_fill(150);

        // output held off while the sender keeps offering
        set_phase(8'd3, 16'd200);
        random_fill(110);
        hold_token++;

        // widest settings: one full press and release on key 0
        set_phase(CNT_MAX, 16'hFFFF);
        key_gesture(0, 258);
        noise(4);

        // sender pause until every event is back, mid-phase
        set_phase(8'd1, 16'($urandom_range(1, 3000)));
        random_fill(100);
        wait_drained();
        cur_tick = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        random_fill(100);

        // last part runs with no idling on either side
        set_phase(8'($urandom_range(0, 4)), 16'($urandom_range(0, 2000)));
        calm = 1'b1;
        random_fill(120);

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d scans and %0d event items over %0d register settings",
                 n_accepted, n_results, settings_used);
        $display("%0d scans reported a key event, %0d mismatches", n_events, err_count);
        if (err_count == 0)
            $display("tb_key_debounce_short_long_press passed");
        else
            $display("tb_key_debounce_short_long_press failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/kdsl_pkg.sv
rtl/core/kdsl_cell.sv
rtl/core/key_debounce_short_long_press.sv
rtl/core/kdsl_checker.sv
sim/tb_key_debounce_short_long_press.sv
